### src/ttia_pkg.sv
// ----------------------------------------------------------------------------
// ttia_pkg
// Shared types, constants and helpers of the transaction table with id
// allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package ttia_pkg;

  localparam int unsigned ENTRIES  = 16;
  localparam int unsigned SLOT_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CNT_W    = $clog2(ENTRIES + 1);

  localparam int unsigned QDEPTH   = 2;
  localparam int unsigned QPTR_W   = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int unsigned QCNT_W   = $clog2(QDEPTH + 1);

  localparam int unsigned CMD_W    = 3;
  localparam int unsigned PROTO_W  = 4;
  localparam int unsigned IDENT_W  = 8;
  localparam int unsigned CREF_W   = 32;
  localparam int unsigned SLOTIO_W = 4;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned MASK_W   = 16;
  localparam int unsigned MID_W    = 4;

  localparam logic [IDENT_W-1:0] ID_UNASSIGNED = 8'hff;
  localparam logic [MID_W-1:0]   ID_FLAG       = 4'h8;
  localparam int unsigned        ID_SPAN       = 7;
  localparam int unsigned        ID_TOP        = 6;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD      = 3'd0,
    CMD_REMOVE   = 3'd1,
    CMD_FIND_ID  = 3'd2,
    CMD_FIND_REF = 3'd3,
    CMD_ASSIGN   = 3'd4
  } cmd_e;

  typedef enum logic [2:0] {
    OP_ADD,
    OP_REMOVE,
    OP_FIND_ID,
    OP_FIND_REF,
    OP_ASSIGN,
    OP_NONE
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2,
    ST_NO_ID     = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_PICK
  } state_e;

  typedef struct packed {
    op_e                 op;
    logic [PROTO_W-1:0]  proto;
    logic [IDENT_W-1:0]  ident;
    logic [CREF_W-1:0]   cref;
    logic [SLOT_W-1:0]   slot;
    logic                flag;
  } req_t;

  typedef struct packed {
    logic [PROTO_W-1:0]  proto;
    logic [IDENT_W-1:0]  ident;
    logic [CREF_W-1:0]   cref;
  } entry_t;

  typedef struct packed {
    status_e              status;
    logic [SLOTIO_W-1:0]  slot;
    logic [PROTO_W-1:0]   proto;
    logic [IDENT_W-1:0]   ident;
    logic [CREF_W-1:0]    cref;
  } rsp_t;

  function automatic logic [SLOTIO_W-1:0] slot_to_out(input logic [SLOT_W-1:0] idx);
    logic [SLOT_W+SLOTIO_W-1:0] w;
    w = {{SLOTIO_W{1'b0}}, idx};
    return w[SLOTIO_W-1:0];
  endfunction

  function automatic logic [SLOT_W-1:0] out_to_slot(input logic [SLOTIO_W-1:0] s);
    logic [SLOT_W+SLOTIO_W-1:0] w;
    w = {{SLOT_W{1'b0}}, s};
    return w[SLOT_W-1:0];
  endfunction

endpackage

`default_nettype wire

### src/transaction_table_with_id_allocator.sv
// ----------------------------------------------------------------------------
// transaction_table_with_id_allocator
// Table of transactions (protocol, id, call reference) with add, remove,
// find by id, find by call reference and free-id assignment.
//
//   channel   direction  handshake                  payload
//   request   in         in_valid_i / in_ready_o    cmd, protocol, trans_ident,
//                                                   call_ref, slot_in, flag_bit
//   result    out        out_valid_o / out_ready_i  status, slot_out,
//                                                   out_protocol, out_ident,
//                                                   out_call_ref
//
// Remove and unknown commands: result registered in the cycle after leaving the queue.
// Add and finds: scan the entries, one entry RAM read per cycle, up to the first hit.
// Assign: the scan builds the used-id mask, then the pick state chooses a free id.
// Reset clears the valid bits, not the entry storage; entries are written before use.
// A two-deep request queue lets input keep flowing while the result waits.
// ----------------------------------------------------------------------------
`default_nettype none

module transaction_table_with_id_allocator (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic [ttia_pkg::CMD_W-1:0]    cmd_i,
  input  wire logic [ttia_pkg::PROTO_W-1:0]  protocol_i,
  input  wire logic [ttia_pkg::IDENT_W-1:0]  trans_ident_i,
  input  wire logic [ttia_pkg::CREF_W-1:0]   call_ref_i,
  input  wire logic [ttia_pkg::SLOTIO_W-1:0] slot_in_i,
  input  wire logic                          flag_bit_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic [ttia_pkg::STATUS_W-1:0]      status_o,
  output logic [ttia_pkg::SLOTIO_W-1:0]      slot_out_o,
  output logic [ttia_pkg::PROTO_W-1:0]       out_protocol_o,
  output logic [ttia_pkg::IDENT_W-1:0]       out_ident_o,
  output logic [ttia_pkg::CREF_W-1:0]        out_call_ref_o
);

  logic            push;
  logic            push_ready;
  ttia_pkg::req_t  push_item;
  logic            q_valid;
  logic            q_pop;
  ttia_pkg::req_t  q_item;
  ttia_pkg::rsp_t  rsp;

  ttia_front u_front (
    .cmd_i         (cmd_i),
    .protocol_i    (protocol_i),
    .trans_ident_i (trans_ident_i),
    .call_ref_i    (call_ref_i),
    .slot_in_i     (slot_in_i),
    .flag_bit_i    (flag_bit_i),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .push_o        (push),
    .push_item_o   (push_item),
    .push_ready_i  (push_ready)
  );

  ttia_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (push_item),
    .ready_o (push_ready),
    .pop_i   (q_pop),
    .item_o  (q_item),
    .valid_o (q_valid)
  );

  ttia_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (q_valid),
    .req_i       (q_item),
    .pop_o       (q_pop),
    .rsp_o       (rsp),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i)
  );

  assign status_o       = rsp.status;
  assign slot_out_o     = rsp.slot;
  assign out_protocol_o = rsp.proto;
  assign out_ident_o    = rsp.ident;
  assign out_call_ref_o = rsp.cref;

endmodule

`default_nettype wire

### src/ttia_ram.sv
// ----------------------------------------------------------------------------
// ttia_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module ttia_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

### src/ttia_front.sv
// ----------------------------------------------------------------------------
// ttia_front
// Request decode: maps the command code to an operation and screens out
// unknown commands and out-of-range slot removals.
// ----------------------------------------------------------------------------
`default_nettype none

module ttia_front (
  input  wire logic [ttia_pkg::CMD_W-1:0]    cmd_i,
  input  wire logic [ttia_pkg::PROTO_W-1:0]  protocol_i,
  input  wire logic [ttia_pkg::IDENT_W-1:0]  trans_ident_i,
  input  wire logic [ttia_pkg::CREF_W-1:0]   call_ref_i,
  input  wire logic [ttia_pkg::SLOTIO_W-1:0] slot_in_i,
  input  wire logic                          flag_bit_i,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  output logic                               push_o,
  output ttia_pkg::req_t                     push_item_o,
  input  wire logic                          push_ready_i
);

  logic slot_in_range;

  assign slot_in_range = 32'(slot_in_i) < 32'(ttia_pkg::ENTRIES);
  assign in_ready_o    = push_ready_i;
  assign push_o        = in_valid_i;

  always_comb begin
    push_item_o.proto = protocol_i;
    push_item_o.ident = trans_ident_i;
    push_item_o.cref  = call_ref_i;
    push_item_o.slot  = ttia_pkg::out_to_slot(slot_in_i);
    push_item_o.flag  = flag_bit_i;
    case (cmd_i)
      ttia_pkg::CMD_ADD:      push_item_o.op = ttia_pkg::OP_ADD;
      ttia_pkg::CMD_REMOVE:   push_item_o.op = slot_in_range ? ttia_pkg::OP_REMOVE
                                                             : ttia_pkg::OP_NONE;
      ttia_pkg::CMD_FIND_ID:  push_item_o.op = ttia_pkg::OP_FIND_ID;
      ttia_pkg::CMD_FIND_REF: push_item_o.op = ttia_pkg::OP_FIND_REF;
      ttia_pkg::CMD_ASSIGN:   push_item_o.op = ttia_pkg::OP_ASSIGN;
      default:                push_item_o.op = ttia_pkg::OP_NONE;
    endcase
  end

endmodule

`default_nettype wire

### src/ttia_fifo.sv
// ----------------------------------------------------------------------------
// ttia_fifo
// Short request queue between decode and the table engine.
// ----------------------------------------------------------------------------
`default_nettype none

module ttia_fifo (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  ttia_pkg::req_t      item_i,
  output logic                ready_o,
  input  wire logic           pop_i,
  output ttia_pkg::req_t      item_o,
  output logic                valid_o
);

  localparam logic [ttia_pkg::QPTR_W-1:0] PTR_LAST = ttia_pkg::QPTR_W'(ttia_pkg::QDEPTH - 1);

  ttia_pkg::req_t                mem_q [ttia_pkg::QDEPTH];
  logic [ttia_pkg::QPTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [ttia_pkg::QPTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [ttia_pkg::QCNT_W-1:0]   cnt_q, cnt_d;
  logic                          do_push, do_pop;

  assign ready_o = cnt_q != ttia_pkg::QCNT_W'(ttia_pkg::QDEPTH);
  assign valid_o = cnt_q != '0;
  assign item_o  = mem_q[rd_ptr_q];
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

`default_nettype wire

### src/ttia_back.sv
// ----------------------------------------------------------------------------
// ttia_back
// Table engine: valid bits, entry RAM, slot scan for add/find/assign, id
// pick for assign, and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module ttia_back (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       req_valid_i,
  input  ttia_pkg::req_t  req_i,
  output logic            pop_o,
  output ttia_pkg::rsp_t  rsp_o,
  output logic            out_valid_o,
  input  wire logic       out_ready_i
);

  localparam int unsigned SW = ttia_pkg::SLOT_W;

  ttia_pkg::state_e               state_q, state_d;
  ttia_pkg::req_t                 cur_q, cur_d;
  ttia_pkg::rsp_t                 rsp_q, rsp_d;
  logic [ttia_pkg::CNT_W-1:0]     cnt_q, cnt_d;
  logic                           cmp_vld_q, cmp_vld_d;
  logic [SW-1:0]                  cmp_idx_q, cmp_idx_d;
  logic [ttia_pkg::MASK_W-1:0]    used_q, used_d;
  logic [ttia_pkg::ENTRIES-1:0]   valid_q, valid_d;
  logic                           out_vld_q, out_vld_d;

  logic                           out_free;
  logic                           scan_rd;
  logic                           cmp_last;
  logic                           cmp_valid_e;
  logic                           scan_hit;
  logic                           used_hit;
  logic                           ram_we;
  logic [SW-1:0]                  ram_waddr;
  ttia_pkg::entry_t               ram_wdata;
  ttia_pkg::entry_t               entry;
  logic [$bits(ttia_pkg::entry_t)-1:0] ram_rdata;

  logic [ttia_pkg::MID_W-1:0]     fl;
  logic [2:0]                     h;
  logic [ttia_pkg::MID_W-1:0]     t;
  logic [ttia_pkg::MID_W-1:0]     j;
  logic                           pick_ok;
  logic [ttia_pkg::MID_W-1:0]     pick_id;

  ttia_ram #(
    .WIDTH ($bits(ttia_pkg::entry_t)),
    .DEPTH (ttia_pkg::ENTRIES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (cnt_q[SW-1:0]),
    .rdata_o (ram_rdata)
  );

  assign entry       = ttia_pkg::entry_t'(ram_rdata);
  assign out_free    = !out_vld_q || out_ready_i;
  assign pop_o       = (state_q == ttia_pkg::S_IDLE) && req_valid_i && out_free;
  assign scan_rd     = (state_q == ttia_pkg::S_SCAN) &&
                       (cnt_q < ttia_pkg::CNT_W'(ttia_pkg::ENTRIES));
  assign cmp_last    = cmp_idx_q == SW'(ttia_pkg::ENTRIES - 1);
  assign cmp_valid_e = valid_q[cmp_idx_q];
  assign ram_waddr   = cmp_idx_q;
  assign ram_wdata   = '{proto: cur_q.proto, ident: cur_q.ident, cref: cur_q.cref};

  assign used_hit = cmp_vld_q && cmp_valid_e && (entry.proto == cur_q.proto) &&
                    (entry.ident != ttia_pkg::ID_UNASSIGNED) &&
                    (entry.ident < ttia_pkg::IDENT_W'(ttia_pkg::MASK_W));

  always_comb begin
    scan_hit = 1'b0;
    if (cmp_vld_q) begin
      case (cur_q.op)
        ttia_pkg::OP_ADD:      scan_hit = !cmp_valid_e;
        ttia_pkg::OP_FIND_ID:  scan_hit = cmp_valid_e && (entry.proto == cur_q.proto) &&
                                          (entry.ident == cur_q.ident);
        ttia_pkg::OP_FIND_REF: scan_hit = cmp_valid_e && (entry.cref == cur_q.cref);
        default:               scan_hit = 1'b0;
      endcase
    end
  end

  // id pick: start at highest used id among 1..6, search circularly
  always_comb begin
    fl      = cur_q.flag ? ttia_pkg::ID_FLAG : '0;
    h       = '0;
    t       = '0;
    j       = '0;
    pick_ok = 1'b0;
    pick_id = '0;
    for (int hh = 1; hh <= int'(ttia_pkg::ID_TOP); hh++) begin
      if (used_q[ttia_pkg::MID_W'(hh) | fl]) begin
        h = 3'(hh);
      end
    end
    for (int i = int'(ttia_pkg::ID_SPAN) - 1; i >= 0; i--) begin
      t = ttia_pkg::MID_W'(h) + ttia_pkg::MID_W'(i);
      if (t >= ttia_pkg::MID_W'(ttia_pkg::ID_SPAN)) begin
        t = t - ttia_pkg::MID_W'(ttia_pkg::ID_SPAN);
      end
      j = t | fl;
      if (!used_q[j]) begin
        pick_ok = 1'b1;
        pick_id = j;
      end
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ttia_pkg::S_IDLE: begin
        if (pop_o && req_i.op inside {ttia_pkg::OP_ADD, ttia_pkg::OP_FIND_ID,
                                      ttia_pkg::OP_FIND_REF, ttia_pkg::OP_ASSIGN}) begin
          state_d = ttia_pkg::S_SCAN;
        end
      end
      ttia_pkg::S_SCAN: begin
        if (scan_hit) begin
          state_d = ttia_pkg::S_IDLE;
        end else if (cmp_vld_q && cmp_last) begin
          state_d = (cur_q.op == ttia_pkg::OP_ASSIGN) ? ttia_pkg::S_PICK : ttia_pkg::S_IDLE;
        end
      end
      ttia_pkg::S_PICK: state_d = ttia_pkg::S_IDLE;
      default:          state_d = ttia_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    cur_d     = cur_q;
    rsp_d     = rsp_q;
    cnt_d     = cnt_q;
    cmp_vld_d = 1'b0;
    cmp_idx_d = cmp_idx_q;
    used_d    = used_q;
    valid_d   = valid_q;
    out_vld_d = out_vld_q && !out_ready_i;
    ram_we    = 1'b0;
    case (state_q)
      ttia_pkg::S_IDLE: begin
        if (pop_o) begin
          cur_d  = req_i;
          cnt_d  = '0;
          used_d = '0;
          if (req_i.op == ttia_pkg::OP_REMOVE) begin
            out_vld_d = 1'b1;
            if (valid_q[req_i.slot]) begin
              valid_d[req_i.slot] = 1'b0;
              rsp_d = '{status: ttia_pkg::ST_OK, slot: ttia_pkg::slot_to_out(req_i.slot),
                        proto: '0, ident: '0, cref: '0};
            end else begin
              rsp_d = '{status: ttia_pkg::ST_NOT_FOUND, slot: '0,
                        proto: '0, ident: '0, cref: '0};
            end
          end else if (req_i.op == ttia_pkg::OP_NONE) begin
            out_vld_d = 1'b1;
            rsp_d = '{status: ttia_pkg::ST_NOT_FOUND, slot: '0,
                      proto: '0, ident: '0, cref: '0};
          end
        end
      end
      ttia_pkg::S_SCAN: begin
        cmp_vld_d = scan_rd;
        cmp_idx_d = cnt_q[SW-1:0];
        if (scan_rd) begin
          cnt_d = cnt_q + 1'b1;
        end
        if (used_hit && cur_q.op == ttia_pkg::OP_ASSIGN) begin
          used_d = used_q | (ttia_pkg::MASK_W'(1) << entry.ident[ttia_pkg::MID_W-1:0]);
        end
        if (scan_hit) begin
          cmp_vld_d = 1'b0;
          out_vld_d = 1'b1;
          if (cur_q.op == ttia_pkg::OP_ADD) begin
            ram_we             = 1'b1;
            valid_d[cmp_idx_q] = 1'b1;
            rsp_d = '{status: ttia_pkg::ST_OK, slot: ttia_pkg::slot_to_out(cmp_idx_q),
                      proto: cur_q.proto, ident: cur_q.ident, cref: cur_q.cref};
          end else begin
            rsp_d = '{status: ttia_pkg::ST_OK, slot: ttia_pkg::slot_to_out(cmp_idx_q),
                      proto: entry.proto, ident: entry.ident, cref: entry.cref};
          end
        end else if (cmp_vld_q && cmp_last && cur_q.op != ttia_pkg::OP_ASSIGN) begin
          out_vld_d = 1'b1;
          rsp_d = '{status: (cur_q.op == ttia_pkg::OP_ADD) ? ttia_pkg::ST_FULL
                                                          : ttia_pkg::ST_NOT_FOUND,
                    slot: '0, proto: '0, ident: '0, cref: '0};
        end
      end
      ttia_pkg::S_PICK: begin
        out_vld_d = 1'b1;
        rsp_d = '{status: pick_ok ? ttia_pkg::ST_OK : ttia_pkg::ST_NO_ID, slot: '0,
                  proto: '0, ident: pick_ok ? {4'b0, pick_id} : '0, cref: '0};
      end
      default: begin
        cmp_vld_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ttia_pkg::S_IDLE;
      cmp_vld_q <= 1'b0;
      valid_q   <= '0;
      out_vld_q <= 1'b0;
      cnt_q     <= '0;
    end else begin
      state_q   <= state_d;
      cmp_vld_q <= cmp_vld_d;
      valid_q   <= valid_d;
      out_vld_q <= out_vld_d;
      cnt_q     <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cur_q     <= cur_d;
    rsp_q     <= rsp_d;
    cmp_idx_q <= cmp_idx_d;
    used_q    <= used_d;
  end

  assign rsp_o       = rsp_q;
  assign out_valid_o = out_vld_q;

  a_out_empty_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != ttia_pkg::S_IDLE |-> !out_vld_q)
    else $error("result register busy during scan");

  a_add_free_slot : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> !valid_q[ram_waddr])
    else $error("add overwrote a live entry");

  a_pick_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ttia_pkg::S_PICK |=> out_vld_q && state_q == ttia_pkg::S_IDLE)
    else $error("id pick gave no result");

  a_valid_one_bit : assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> $countones(valid_q ^ $past(valid_q)) <= 1)
    else $error("more than one slot changed at once");

endmodule

`default_nettype wire
